// ===== src/quaternion_vector_rotate_core_defines.svh =====
// ---------------------------------------------------------------------------
// quaternion vector rotate core assertion macros
// shared concurrent assertion forms for the rotate core
// ---------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH

// check that holds at every edge, reset included
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

// check that is switched off while reset is high
`define QVR_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== src/qvr_pkg.sv =====
// ---------------------------------------------------------------------------
// qvr_pkg
// widths, payload types and register codes for the quaternion rotate core
// ---------------------------------------------------------------------------
package qvr_pkg;

   // coordinate and fixed point format
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int QUAT_BITS  = FRAC_BITS + 2;

   // first product: d is one bit wider than a coordinate, three terms summed
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int P1_BITS   = DIFF_BITS + QUAT_BITS;
   localparam int S1_BITS   = P1_BITS + 2;
   localparam int T_BITS    = S1_BITS - FRAC_BITS;

   // second product: four terms summed, then pivot added back
   localparam int P2_BITS  = T_BITS + QUAT_BITS;
   localparam int S2_BITS  = P2_BITS + 2;
   localparam int R_BITS   = S2_BITS - FRAC_BITS;
   localparam int SUM_BITS = R_BITS + 1;

   // rounding offsets, half an lsb of the result
   localparam logic signed [S1_BITS-1:0] ROUND1 = S1_BITS'(1) << (FRAC_BITS - 1);
   localparam logic signed [S2_BITS-1:0] ROUND2 = S2_BITS'(1) << (FRAC_BITS - 1);

   // configuration register index
   localparam int CSR_ADDR_BITS = 2;
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_QUAT_X = 2'd0,
      CSR_QUAT_Y = 2'd1,
      CSR_QUAT_Z = 2'd2,
      CSR_QUAT_W = 2'd3
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] x;
      logic signed [QUAT_BITS-1:0] y;
      logic signed [QUAT_BITS-1:0] z;
      logic signed [QUAT_BITS-1:0] w;
   } quat_type;

   typedef struct packed {
      coord_type vec_x;
      coord_type vec_y;
      coord_type vec_z;
      coord_type pivot_x;
      coord_type pivot_y;
      coord_type pivot_z;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      logic      saturated;
   } rsp_type;

   // first hamilton product result with the pivot carried along
   typedef struct packed {
      logic signed [T_BITS-1:0] tx;
      logic signed [T_BITS-1:0] ty;
      logic signed [T_BITS-1:0] tz;
      logic signed [T_BITS-1:0] tw;
      coord_type                px;
      coord_type                py;
      coord_type                pz;
   } tprod_type;

   // rotated point before clamping
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sx;
      logic signed [SUM_BITS-1:0] sy;
      logic signed [SUM_BITS-1:0] sz;
   } point_type;

endpackage

// ===== src/quaternion_vector_rotate_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_vector_rotate_core: rotate a vector about a pivot by a quaternion
// pipeline: six stages between request accept and rsp_valid
// throughput: one request per cycle; a stalled response only halts full stages
// reset: clears all valid bits and loads the identity quaternion
// ---------------------------------------------------------------------------
`include "quaternion_vector_rotate_core_defines.svh"

module quaternion_vector_rotate_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  qvr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output qvr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [qvr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [qvr_pkg::QUAT_BITS-1:0]     csr_wdata
);
   import qvr_pkg::*;

   localparam coord_type COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

   quat_type  quat;
   logic      req_ready;
   logic      t_valid, t_ready;
   tprod_type t_data;
   logic      p_valid, p_ready;
   point_type p_data;
   logic      w_write;
   logic      sat_seen, any_limit;

   // quaternion registers
   qvr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .quat      (quat)
   );

   // q * (d, 0)
   qvr_ham1 u_ham1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .quat      (quat),
      .out_valid (t_valid),
      .out_ready (t_ready),
      .out_data  (t_data)
   );

   // t * conj(q) plus pivot
   qvr_ham2 u_ham2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .in_ready  (t_ready),
      .in_data   (t_data),
      .quat      (quat),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_data  (p_data)
   );

   // saturation and response register
   qvr_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_data   (p_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !req_ready;

   // conditions watched by the checks below
   assign w_write   = csr_wr_en && (csr_addr == CSR_QUAT_W);
   assign sat_seen  = rsp_valid && rsp_data.saturated;
   assign any_limit = (rsp_data.out_x == COORD_HI) || (rsp_data.out_x == COORD_LO)
                   || (rsp_data.out_y == COORD_HI) || (rsp_data.out_y == COORD_LO)
                   || (rsp_data.out_z == COORD_HI) || (rsp_data.out_z == COORD_LO);

   // the first cycle after reset carries no response
   `QVR_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid after reset")

   // requests are held off only when every stage is full and the output is stalled
   `QVR_ASSERT_RUN(a_stall_full, req_stall |-> (rsp_valid && rsp_stall), "stall with room")

   // a saturated flag means at least one coordinate sits at a range limit
   `QVR_ASSERT_RUN(a_sat_limit, sat_seen |-> any_limit, "saturated flag without clamp")

   // a write to the scalar register lands in the quaternion
   `QVR_ASSERT_RUN(a_csr_w, w_write |=> (quat.w == $past(csr_wdata)), "scalar write lost")

endmodule

// ===== src/qvr_csr.sv =====
// ---------------------------------------------------------------------------
// qvr_csr
// quaternion register file, loads identity on reset
// ---------------------------------------------------------------------------
module qvr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [qvr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [qvr_pkg::QUAT_BITS-1:0]     csr_wdata,
   output qvr_pkg::quat_type                 quat
);
   import qvr_pkg::*;

   quat_type quat_ff;
   quat_type quat_in;

   // register write decode
   always_comb begin
      quat_in = quat_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_QUAT_X: quat_in.x = csr_wdata;
            CSR_QUAT_Y: quat_in.y = csr_wdata;
            CSR_QUAT_Z: quat_in.z = csr_wdata;
            CSR_QUAT_W: quat_in.w = csr_wdata;
            default:    quat_in = quat_ff;
         endcase
      end
   end

   // registers, identity quaternion after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x <= '0;
         quat_ff.y <= '0;
         quat_ff.z <= '0;
         quat_ff.w <= QUAT_BITS'(1) << FRAC_BITS;
      end else begin
         quat_ff <= quat_in;
      end
   end

   assign quat = quat_ff;

endmodule

// ===== src/qvr_ham1.sv =====
// ---------------------------------------------------------------------------
// qvr_ham1
// pivot subtract and first hamilton product t = q * (d, 0), three stages
// ---------------------------------------------------------------------------
module qvr_ham1 (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  qvr_pkg::req_type    in_data,
   input  qvr_pkg::quat_type   quat,
   output logic                out_valid,
   input  logic                out_ready,
   output qvr_pkg::tprod_type  out_data
);
   import qvr_pkg::*;

   // round to nearest, ties up, drop the fraction bits
   function automatic logic signed [T_BITS-1:0] round_t(input logic signed [S1_BITS-1:0] s);
      logic signed [S1_BITS-1:0] b;
      b = s + ROUND1;
      return b[S1_BITS-1:FRAC_BITS];
   endfunction

   localparam int NPROD = 12;

   // stage a: difference vector
   logic                       a_valid_ff;
   logic signed [DIFF_BITS-1:0] a_dx_ff, a_dy_ff, a_dz_ff;
   logic signed [DIFF_BITS-1:0] a_dx_in, a_dy_in, a_dz_in;
   coord_type                  a_px_ff, a_py_ff, a_pz_ff;

   // stage b: partial products
   logic                       b_valid_ff;
   logic signed [P1_BITS-1:0]  b_prod_ff [NPROD];
   logic signed [P1_BITS-1:0]  b_prod_in [NPROD];
   coord_type                  b_px_ff, b_py_ff, b_pz_ff;

   // stage c: rounded product
   logic                       c_valid_ff;
   tprod_type                  c_data_ff;
   tprod_type                  c_data_in;

   logic a_ready, b_ready, c_ready;

   // a stage moves when it is empty or the next one moves
   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // pivot subtract, one bit of growth
   always_comb begin
      a_dx_in = DIFF_BITS'(in_data.vec_x) - DIFF_BITS'(in_data.pivot_x);
      a_dy_in = DIFF_BITS'(in_data.vec_y) - DIFF_BITS'(in_data.pivot_y);
      a_dz_in = DIFF_BITS'(in_data.vec_z) - DIFF_BITS'(in_data.pivot_z);
   end

   // twelve products of q with d
   always_comb begin
      b_prod_in[0]  = P1_BITS'(quat.w) * P1_BITS'(a_dx_ff);
      b_prod_in[1]  = P1_BITS'(quat.y) * P1_BITS'(a_dz_ff);
      b_prod_in[2]  = P1_BITS'(quat.z) * P1_BITS'(a_dy_ff);
      b_prod_in[3]  = P1_BITS'(quat.w) * P1_BITS'(a_dy_ff);
      b_prod_in[4]  = P1_BITS'(quat.x) * P1_BITS'(a_dz_ff);
      b_prod_in[5]  = P1_BITS'(quat.z) * P1_BITS'(a_dx_ff);
      b_prod_in[6]  = P1_BITS'(quat.w) * P1_BITS'(a_dz_ff);
      b_prod_in[7]  = P1_BITS'(quat.x) * P1_BITS'(a_dy_ff);
      b_prod_in[8]  = P1_BITS'(quat.y) * P1_BITS'(a_dx_ff);
      b_prod_in[9]  = P1_BITS'(quat.x) * P1_BITS'(a_dx_ff);
      b_prod_in[10] = P1_BITS'(quat.y) * P1_BITS'(a_dy_ff);
      b_prod_in[11] = P1_BITS'(quat.z) * P1_BITS'(a_dz_ff);
   end

   // sums of products and rounding
   always_comb begin
      c_data_in.tx = round_t(S1_BITS'(b_prod_ff[0]) + S1_BITS'(b_prod_ff[1])
                           - S1_BITS'(b_prod_ff[2]));
      c_data_in.ty = round_t(S1_BITS'(b_prod_ff[3]) - S1_BITS'(b_prod_ff[4])
                           + S1_BITS'(b_prod_ff[5]));
      c_data_in.tz = round_t(S1_BITS'(b_prod_ff[6]) + S1_BITS'(b_prod_ff[7])
                           - S1_BITS'(b_prod_ff[8]));
      c_data_in.tw = round_t(-S1_BITS'(b_prod_ff[9]) - S1_BITS'(b_prod_ff[10])
                           - S1_BITS'(b_prod_ff[11]));
      c_data_in.px = b_px_ff;
      c_data_in.py = b_py_ff;
      c_data_in.pz = b_pz_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_dx_ff <= a_dx_in;
         a_dy_ff <= a_dy_in;
         a_dz_ff <= a_dz_in;
         a_px_ff <= in_data.pivot_x;
         a_py_ff <= in_data.pivot_y;
         a_pz_ff <= in_data.pivot_z;
      end
      if (b_ready && a_valid_ff) begin
         b_prod_ff <= b_prod_in;
         b_px_ff   <= a_px_ff;
         b_py_ff   <= a_py_ff;
         b_pz_ff   <= a_pz_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

// ===== src/qvr_ham2.sv =====
// ---------------------------------------------------------------------------
// qvr_ham2
// second hamilton product r = t * conj(q) and pivot add back, two stages
// ---------------------------------------------------------------------------
module qvr_ham2 (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  qvr_pkg::tprod_type  in_data,
   input  qvr_pkg::quat_type   quat,
   output logic                out_valid,
   input  logic                out_ready,
   output qvr_pkg::point_type  out_data
);
   import qvr_pkg::*;

   // round to nearest, ties up, drop the fraction bits
   function automatic logic signed [R_BITS-1:0] round_r(input logic signed [S2_BITS-1:0] s);
      logic signed [S2_BITS-1:0] b;
      b = s + ROUND2;
      return b[S2_BITS-1:FRAC_BITS];
   endfunction

   localparam int NPROD = 12;

   // stage d: partial products
   logic                      d_valid_ff;
   logic signed [P2_BITS-1:0] d_prod_ff [NPROD];
   logic signed [P2_BITS-1:0] d_prod_in [NPROD];
   coord_type                 d_px_ff, d_py_ff, d_pz_ff;

   // stage e: rounded sums plus pivot
   logic                      e_valid_ff;
   point_type                 e_data_ff;
   point_type                 e_data_in;
   logic signed [R_BITS-1:0]  rx, ry, rz;

   logic d_ready, e_ready;

   assign e_ready  = !e_valid_ff || out_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign in_ready = d_ready;

   // twelve products of t with q, conjugate signs folded into the sums
   always_comb begin
      d_prod_in[0]  = P2_BITS'(in_data.tw) * P2_BITS'(quat.x);
      d_prod_in[1]  = P2_BITS'(in_data.tx) * P2_BITS'(quat.w);
      d_prod_in[2]  = P2_BITS'(in_data.ty) * P2_BITS'(quat.z);
      d_prod_in[3]  = P2_BITS'(in_data.tz) * P2_BITS'(quat.y);
      d_prod_in[4]  = P2_BITS'(in_data.tw) * P2_BITS'(quat.y);
      d_prod_in[5]  = P2_BITS'(in_data.tx) * P2_BITS'(quat.z);
      d_prod_in[6]  = P2_BITS'(in_data.ty) * P2_BITS'(quat.w);
      d_prod_in[7]  = P2_BITS'(in_data.tz) * P2_BITS'(quat.x);
      d_prod_in[8]  = P2_BITS'(in_data.tw) * P2_BITS'(quat.z);
      d_prod_in[9]  = P2_BITS'(in_data.tx) * P2_BITS'(quat.y);
      d_prod_in[10] = P2_BITS'(in_data.ty) * P2_BITS'(quat.x);
      d_prod_in[11] = P2_BITS'(in_data.tz) * P2_BITS'(quat.w);
   end

   // sums, rounding and pivot add back
   always_comb begin
      rx = round_r(-S2_BITS'(d_prod_ff[0]) + S2_BITS'(d_prod_ff[1])
                  - S2_BITS'(d_prod_ff[2]) + S2_BITS'(d_prod_ff[3]));
      ry = round_r(-S2_BITS'(d_prod_ff[4]) + S2_BITS'(d_prod_ff[5])
                  + S2_BITS'(d_prod_ff[6]) - S2_BITS'(d_prod_ff[7]));
      rz = round_r(-S2_BITS'(d_prod_ff[8]) - S2_BITS'(d_prod_ff[9])
                  + S2_BITS'(d_prod_ff[10]) + S2_BITS'(d_prod_ff[11]));
      e_data_in.sx = SUM_BITS'(rx) + SUM_BITS'(d_px_ff);
      e_data_in.sy = SUM_BITS'(ry) + SUM_BITS'(d_py_ff);
      e_data_in.sz = SUM_BITS'(rz) + SUM_BITS'(d_pz_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (d_ready) d_valid_ff <= in_valid;
         if (e_ready) e_valid_ff <= d_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (d_ready && in_valid) begin
         d_prod_ff <= d_prod_in;
         d_px_ff   <= in_data.px;
         d_py_ff   <= in_data.py;
         d_pz_ff   <= in_data.pz;
      end
      if (e_ready && d_valid_ff) begin
         e_data_ff <= e_data_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_data_ff;

endmodule

// ===== src/qvr_sat.sv =====
// ---------------------------------------------------------------------------
// qvr_sat
// clamp to the coordinate range and hold the response register
// ---------------------------------------------------------------------------
module qvr_sat (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  qvr_pkg::point_type  in_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output qvr_pkg::rsp_type    rsp_data
);
   import qvr_pkg::*;

   localparam int HI_BITS = SUM_BITS - COORD_BITS + 1;

   // clamp one coordinate, flag when the value does not fit
   function automatic logic [COORD_BITS:0] clamp(input logic signed [SUM_BITS-1:0] v);
      logic [HI_BITS-1:0] top;
      logic               fits;
      top  = v[SUM_BITS-1:COORD_BITS-1];
      fits = (&top) || !(|top);
      if (fits) begin
         return {1'b0, v[COORD_BITS-1:0]};
      end else if (v[SUM_BITS-1]) begin
         return {1'b1, 1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(COORD_BITS-1){1'b1}}};
      end
   endfunction

   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic [COORD_BITS:0] cx, cy, cz;

   assign in_ready = !rsp_valid_ff || !rsp_stall;

   // clamp all three coordinates
   always_comb begin
      cx = clamp(in_data.sx);
      cy = clamp(in_data.sy);
      cz = clamp(in_data.sz);
      rsp_data_in.out_x     = cx[COORD_BITS-1:0];
      rsp_data_in.out_y     = cy[COORD_BITS-1:0];
      rsp_data_in.out_z     = cz[COORD_BITS-1:0];
      rsp_data_in.saturated = cx[COORD_BITS] | cy[COORD_BITS] | cz[COORD_BITS];
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/quaternion_vector_rotate_core_tb.sv =====
// ---------------------------------------------------------------------------
// quaternion_vector_rotate_core_tb
// streams vector and pivot requests through the rotate core under several
// quaternion settings, predicts every rotated point in fixed point and
// compares each response field by field, with random idle on both channels
// ---------------------------------------------------------------------------
module quaternion_vector_rotate_core_tb;
   import qvr_pkg::*;

   localparam int     LIMIT_CYCLES = 200000;
   localparam int     PHASE_COUNT  = 12;
   localparam int     PHASE_ITEMS  = 162;
   localparam longint COORD_MAX    = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN    = -COORD_MAX - 1;
   localparam int     Q_ONE        = 1 << FRAC_BITS;

   // quaternion families used by the random phases
   typedef enum int {
      QK_UNIT,
      QK_AXIS_FLIP,
      QK_SCALED,
      QK_RAW
   } quat_kind_type;

   // fixed point predictor and queue of pending rotated points
   class rotation_checker;
      longint  qx, qy, qz, qw;
      rsp_type expected_points[$];
      int      mismatch_count;

      function new();
         qx = 0;
         qy = 0;
         qz = 0;
         qw = Q_ONE;
         mismatch_count = 0;
      endfunction

      function void load_register(csr_index_type idx, logic [QUAT_BITS-1:0] val);
         longint v;
         v = longint'($signed(val));
         case (idx)
            CSR_QUAT_X: qx = v;
            CSR_QUAT_Y: qy = v;
            CSR_QUAT_Z: qz = v;
            CSR_QUAT_W: qw = v;
            default: ;
         endcase
      endfunction

      // divide by 2^FRAC_BITS, nearest, ties toward plus infinity
      function longint round_half_up(longint a);
         return (a + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      function bit beyond_coord(longint v);
         return (v > COORD_MAX) || (v < COORD_MIN);
      endfunction

      function coord_type clip_coord(longint v);
         if (v > COORD_MAX) return coord_type'(COORD_MAX);
         if (v < COORD_MIN) return coord_type'(COORD_MIN);
         return coord_type'(v);
      endfunction

      function rsp_type rotate_about_pivot(req_type r);
         longint  px, py, pz, dx, dy, dz;
         longint  tx, ty, tz, tw, rx, ry, rz;
         rsp_type res;
         px = $signed(r.pivot_x);
         py = $signed(r.pivot_y);
         pz = $signed(r.pivot_z);
         dx = longint'($signed(r.vec_x)) - px;
         dy = longint'($signed(r.vec_y)) - py;
         dz = longint'($signed(r.vec_z)) - pz;
         // q * (d, 0)
         tx = round_half_up(qw * dx + qy * dz - qz * dy);
         ty = round_half_up(qw * dy - qx * dz + qz * dx);
         tz = round_half_up(qw * dz + qx * dy - qy * dx);
         tw = round_half_up(-(qx * dx) - qy * dy - qz * dz);
         // t * conj(q), scalar part dropped
         rx = round_half_up(-(tw * qx) + tx * qw - ty * qz + tz * qy);
         ry = round_half_up(-(tw * qy) + tx * qz + ty * qw - tz * qx);
         rz = round_half_up(-(tw * qz) - tx * qy + ty * qx + tz * qw);
         // pivot back in, then clamp
         res.out_x     = clip_coord(rx + px);
         res.out_y     = clip_coord(ry + py);
         res.out_z     = clip_coord(rz + pz);
         res.saturated = beyond_coord(rx + px) || beyond_coord(ry + py) ||
                         beyond_coord(rz + pz);
         return res;
      endfunction

      function void note_request(req_type r);
         expected_points.push_back(rotate_about_pivot(r));
      endfunction

      function void compare_field(string name, logic signed [COORD_BITS:0] want,
                                  logic signed [COORD_BITS:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_points.size() == 0) begin
            $error("response with no request pending: %h", got);
            mismatch_count++;
            return;
         end
         want = expected_points.pop_front();
         compare_field("out_x", want.out_x, got.out_x);
         compare_field("out_y", want.out_y, got.out_y);
         compare_field("out_z", want.out_z, got.out_z);
         compare_field("saturated", want.saturated, got.saturated);
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_wr_en;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [QUAT_BITS-1:0]     csr_wdata;

   rotation_checker rotation = new();
   bit              steady = 1'b0;
   int              cycle_count = 0;
   quat_kind_type   phase_kinds [PHASE_COUNT] = '{
      QK_UNIT, QK_AXIS_FLIP, QK_UNIT, QK_SCALED, QK_UNIT, QK_RAW,
      QK_UNIT, QK_AXIS_FLIP, QK_SCALED, QK_UNIT, QK_RAW, QK_UNIT
   };

   quaternion_vector_rotate_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("quaternion_vector_rotate_core_tb: FAIL");
         $finish;
      end
   end

   // response side back pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(0, 99) < 15);
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) rotation.check_response(rsp_data);
   end

   function automatic req_type point_pair(int vx, int vy, int vz, int px, int py, int pz);
      req_type r;
      r.vec_x   = coord_type'(vx);
      r.vec_y   = coord_type'(vy);
      r.vec_z   = coord_type'(vz);
      r.pivot_x = coord_type'(px);
      r.pivot_y = coord_type'(py);
      r.pivot_z = coord_type'(pz);
      return r;
   endfunction

   function automatic quat_type make_quat(int x, int y, int z, int w);
      quat_type q;
      q.x = QUAT_BITS'(x);
      q.y = QUAT_BITS'(y);
      q.z = QUAT_BITS'(z);
      q.w = QUAT_BITS'(w);
      return q;
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(0, 3))
         0:       return coord_type'(COORD_MAX);
         1:       return coord_type'(COORD_MIN);
         2:       return coord_type'(0);
         default: return coord_type'(-1);
      endcase
   endfunction

   function automatic coord_type near_coord();
      return coord_type'(int'($urandom_range(0, 4095)) - 2048);
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      mode;
      mode = $urandom_range(0, 9);
      r = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord()};
      case (mode)
         3, 4: begin
            // rotation about the origin
            r.pivot_x = '0;
            r.pivot_y = '0;
            r.pivot_z = '0;
         end
         5, 6: r = {near_coord(), near_coord(), near_coord(),
                    near_coord(), near_coord(), near_coord()};
         7: begin
            // point close to its pivot
            r.vec_x = r.pivot_x + near_coord();
            r.vec_y = r.pivot_y + near_coord();
            r.vec_z = r.pivot_z + near_coord();
         end
         8: r = {edge_coord(), edge_coord(), edge_coord(),
                 edge_coord(), edge_coord(), edge_coord()};
         9: begin
            r.vec_x = near_coord();
            r.vec_y = near_coord();
            r.vec_z = near_coord();
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic quat_type pick_quaternion(quat_kind_type kind);
      real a, b, c, d, n;
      int  sgn;
      case (kind)
         QK_AXIS_FLIP: begin
            // half turn about one axis, or plus or minus identity
            sgn = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
            case ($urandom_range(0, 3))
               0:       return make_quat(sgn, 0, 0, 0);
               1:       return make_quat(0, sgn, 0, 0);
               2:       return make_quat(0, 0, sgn, 0);
               default: return make_quat(0, 0, 0, sgn);
            endcase
         end
         QK_SCALED: return make_quat(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                     int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                     int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                     int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
         QK_RAW: return make_quat($urandom, $urandom, $urandom, $urandom);
         default: begin
            a = int'($urandom_range(0, 65534)) - 32767;
            b = int'($urandom_range(0, 65534)) - 32767;
            c = int'($urandom_range(0, 65534)) - 32767;
            d = int'($urandom_range(0, 65534)) - 32767;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) return make_quat(0, 0, 0, Q_ONE);
            return make_quat(int'(a / n * Q_ONE), int'(b / n * Q_ONE),
                             int'(c / n * Q_ONE), int'(d / n * Q_ONE));
         end
      endcase
   endfunction

   // present one request, with an occasional idle gap, until accepted
   task automatic send_request(input req_type item);
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rotation.note_request(item);
   endtask

   // stop requesting and let every pending point come back
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rotation.pending() != 0) @(posedge clock);
   endtask

   // write all four quaternion registers while the core is idle
   task automatic load_quaternion(input quat_type q);
      csr_index_type        idx;
      logic [QUAT_BITS-1:0] val;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_QUAT_X: val = q.x;
            CSR_QUAT_Y: val = q.y;
            CSR_QUAT_Z: val = q.z;
            default:    val = q.w;
         endcase
         csr_wr_en <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= val;
         @(posedge clock);
         rotation.load_register(idx, val);
      end
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_addr  <= CSR_QUAT_X;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // identity after reset, coordinate extremes and widest differences
      send_request(point_pair(0, 0, 0, 0, 0, 0));
      send_request(point_pair(32767, 32767, 32767, 0, 0, 0));
      send_request(point_pair(-32768, -32768, -32768, 0, 0, 0));
      send_request(point_pair(32767, 32767, 32767, -32768, -32768, -32768));
      send_request(point_pair(-32768, -32768, -32768, 32767, 32767, 32767));
      send_request(point_pair(1234, -4321, 77, 1234, -4321, 77));
      send_request(point_pair(21845, -21846, 1, -21846, 21845, -1));
      drain_requests();

      // register values beyond plus or minus one
      load_quaternion(make_quat(32767, -32768, 32767, -32768));
      send_request(point_pair(100, -200, 300, 0, 0, 0));
      send_request(point_pair(32767, -32768, 32767, -32768, 32767, -32768));
      send_request(point_pair(-32768, 32767, -32768, 32767, -32768, 32767));
      send_request(point_pair(0, 0, 0, 0, 0, 0));
      drain_requests();

      // non unit quaternion scales by its squared norm
      load_quaternion(make_quat(Q_ONE, Q_ONE, Q_ONE, Q_ONE));
      send_request(point_pair(10000, -10000, 5000, 0, 0, 0));
      send_request(point_pair(3, -7, 1, -32768, 32767, 0));
      drain_requests();

      // quarter turn about z, including rounding ties on small values
      load_quaternion(make_quat(0, 0, 11585, 11585));
      send_request(point_pair(1000, 0, 0, 0, 0, 0));
      send_request(point_pair(1000, 0, 0, 500, 500, 0));
      send_request(point_pair(32767, -32768, 0, 0, 0, 0));
      send_request(point_pair(1, 1, 1, 0, 0, 0));
      send_request(point_pair(-1, -1, -1, 0, 0, 0));
      drain_requests();

      // zero quaternion collapses every point onto its pivot
      load_quaternion(make_quat(0, 0, 0, 0));
      send_request(point_pair(5555, -6666, 7777, 123, -456, 789));
      drain_requests();

      // negated identity
      load_quaternion(make_quat(0, 0, 0, -Q_ONE));
      send_request(point_pair(-30000, 20000, -10000, 40, -50, 60));
      drain_requests();

      // random phases, one of them with no idling on either side
      for (int p = 0; p < PHASE_COUNT; p++) begin
         load_quaternion(pick_quaternion(phase_kinds[p]));
         steady = (p == 5);
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
         drain_requests();
      end
      steady = 1'b0;

      // catch any stray response after the last one
      repeat (16) @(posedge clock);
      if (rotation.mismatch_count == 0 && rotation.pending() == 0) begin
         $display("quaternion_vector_rotate_core_tb: PASS");
      end else begin
         $display("quaternion_vector_rotate_core_tb: FAIL");
      end
      $finish;
   end

endmodule
